[sv/mft_pkg.sv]
// Shared types and constants for the motor feedback tracker.
`timescale 1ns / 1ps

package mft_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_OFFLINE_LIMIT = 2'd0;
    localparam logic [1:0] REG_COUNT_MASK    = 2'd1;

    // Operation codes carried by an input transaction.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Reset values of the configuration registers and the silence counters.
    localparam logic [15:0] RESET_OFFLINE_LIMIT = 16'd50;
    localparam logic [15:0] RESET_COUNT_MASK    = 16'hFFFF;
    localparam logic [15:0] RESET_SILENCE       = 16'd51;

    // Encoder unwrap thresholds: half a turn and a full turn in counts.
    localparam logic signed [16:0] HALF_TURN = 17'sd4095;
    localparam logic signed [16:0] FULL_TURN = 17'sd8191;

    // Per-lane command from the shared control to one motor lane.
    typedef struct packed {
        logic update;  // the transaction in the input register retires this cycle
        logic frame;   // feedback frame addressed to this lane
        logic tick;    // heartbeat tick for all lanes
    } t_lane_cmd;

endpackage

[sv/motor_feedback_tracker.sv]
// Top level of the motor feedback tracker: input register, motor lanes and result register.
`timescale 1ns / 1ps

// The tracker keeps one lane of state per motor: the last raw angle, a 32-bit
// multi-turn angle sum, a seeded flag, a silence counter and an offline flag.
// A feedback frame transaction (op = 0) unpacks the seven raw bytes, unwraps
// the angle of the addressed motor into its sum and clears that motor's
// silence counter; a frame for an index at or above NUM_MOTORS only echoes the
// unpacked fields with a zero sum. A heartbeat tick transaction (op = 1)
// advances every silence counter at once and re-evaluates every offline flag
// against offline_limit; its result carries zeros in all per-frame fields.
// Every input transaction yields exactly one result transaction carrying the
// offline mask of the first sixteen motors and the number of those offline
// motors selected by count_mask. The block takes one transaction per clock
// cycle unless o_in_stall holds it off. An accepted transaction waits in the
// input register, where the lanes compute their next state, and its result is
// then captured in the result register and presented from there. The result
// register lets a new transaction enter while the previous result is still
// stalled; the input side stalls only when both registers are full and the
// result is stalled. Configuration writes (index 0 offline_limit, index 1
// count_mask, other indexes ignored) are to be issued only while the block is
// idle; a new offline_limit takes effect at the next tick.
module motor_feedback_tracker
    import mft_pkg::*;
#(
    parameter int NUM_MOTORS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [3:0]         i_motor_index,
    input  logic [7:0]         i_byte0,
    input  logic [7:0]         i_byte1,
    input  logic [7:0]         i_byte2,
    input  logic [7:0]         i_byte3,
    input  logic [7:0]         i_byte4,
    input  logic [7:0]         i_byte5,
    input  logic [7:0]         i_byte6,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_out_motor,
    output logic [15:0]        o_angle_raw,
    output logic signed [15:0] o_speed,
    output logic signed [15:0] o_current,
    output logic [7:0]         o_temperature,
    output logic signed [31:0] o_angle_total,
    output logic [15:0]        o_offline_flags,
    output logic [4:0]         o_offline_total
);

    // Configuration registers.
    logic [15:0] r_offline_limit;
    logic [15:0] r_count_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offline_limit <= RESET_OFFLINE_LIMIT;
            r_count_mask    <= RESET_COUNT_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OFFLINE_LIMIT: r_offline_limit <= i_cfg_data;
                REG_COUNT_MASK:    r_count_mask    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register. It advances whenever the result register is free or
    // is being emptied in this cycle.
    logic        r_in_valid;
    logic        r_op;
    logic [3:0]  r_motor_index;
    logic [15:0] r_angle;
    logic [15:0] r_speed;
    logic [15:0] r_current;
    logic [7:0]  r_temp;

    logic r_out_valid;
    logic advance;
    logic in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op          <= i_op;
            r_motor_index <= i_motor_index;
            r_angle       <= {i_byte0, i_byte1};
            r_speed       <= {i_byte2, i_byte3};
            r_current     <= {i_byte4, i_byte5};
            r_temp        <= i_byte6;
        end
    end

    // Motor lanes. Each lane decodes its own hit; the sum of the addressed
    // lane is picked by an AND-OR over the one-hot hits.
    logic               is_frame;
    logic               is_tick;
    logic [NUM_MOTORS-1:0] lane_hit;
    logic [NUM_MOTORS-1:0] lane_offline;
    logic signed [31:0]    lane_sum [NUM_MOTORS];

    assign is_frame = (r_op == OP_FRAME);
    assign is_tick  = (r_op == OP_TICK);

    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
        t_lane_cmd cmd;

        assign lane_hit[g] = is_frame && ({2'b00, r_motor_index} == 6'(g));
        assign cmd.update  = advance;
        assign cmd.frame   = lane_hit[g];
        assign cmd.tick    = is_tick;

        mft_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_cmd           (cmd),
            .i_angle         (r_angle),
            .i_offline_limit (r_offline_limit),
            .o_sum_next      (lane_sum[g]),
            .o_offline_next  (lane_offline[g])
        );
    end

    logic signed [31:0] sel_sum;

    always_comb begin
        sel_sum = '0;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            sel_sum = sel_sum | (lane_hit[i] ? lane_sum[i] : 32'sd0);
        end
    end

    // Only the first sixteen motors are reported in the mask.
    logic [15:0] flags;

    for (genvar f = 0; f < 16; f++) begin : g_flag
        if (f < NUM_MOTORS) begin : g_used
            assign flags[f] = lane_offline[f];
        end else begin : g_unused
            assign flags[f] = 1'b0;
        end
    end

    logic [15:0] counted;
    logic [4:0]  total;

    assign counted = flags & r_count_mask;

    always_comb begin
        total = '0;
        for (int i = 0; i < 16; i++) begin
            total = total + 5'(counted[i]);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_out_motor     <= is_frame ? r_motor_index : '0;
            o_angle_raw     <= is_frame ? r_angle : '0;
            o_speed         <= is_frame ? r_speed : '0;
            o_current       <= is_frame ? r_current : '0;
            o_temperature   <= is_frame ? r_temp : '0;
            o_angle_total   <= sel_sum;
            o_offline_flags <= flags;
            o_offline_total <= total;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/mft_lane.sv]
// State of one motor: angle unwrap, multi-turn sum, silence counter and offline flag.
`timescale 1ns / 1ps

module mft_lane
    import mft_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_cmd          i_cmd,
    input  logic [15:0]        i_angle,
    input  logic [15:0]        i_offline_limit,
    output logic signed [31:0] o_sum_next,
    output logic               o_offline_next
);

    logic [15:0]        r_prev;
    logic signed [31:0] r_sum;
    logic               r_seen;
    logic [15:0]        r_count;
    logic               r_offline;

    logic [15:0]        n_count;
    logic [15:0]        prev_eff;
    logic signed [31:0] sum_base;
    logic signed [16:0] diff;
    logic signed [16:0] step;
    logic [16:0]        count_inc;

    // The first frame seeds the previous angle and restarts the sum.
    assign prev_eff = r_seen ? r_prev : i_angle;
    assign sum_base = r_seen ? r_sum : 32'sd0;
    assign diff     = 17'(signed'(i_angle - prev_eff));

    always_comb begin
        if (diff > HALF_TURN) begin
            step = diff - FULL_TURN;
        end else if (diff < -HALF_TURN) begin
            step = diff + FULL_TURN;
        end else begin
            step = diff;
        end
    end

    assign o_sum_next = sum_base + 32'(step);

    assign count_inc = {1'b0, r_count} + 17'd1;

    always_comb begin
        n_count        = r_count;
        o_offline_next = r_offline;
        if (i_cmd.tick) begin
            if (count_inc > {1'b0, i_offline_limit}) begin
                n_count        = i_offline_limit;
                o_offline_next = 1'b1;
            end else begin
                n_count        = count_inc[15:0];
                o_offline_next = 1'b0;
            end
        end else if (i_cmd.frame) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_count   <= RESET_SILENCE;
            r_offline <= 1'b1;
        end else if (i_cmd.update) begin
            r_count   <= n_count;
            r_offline <= o_offline_next;
            if (i_cmd.frame) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && i_cmd.frame) begin
            r_prev <= i_angle;
            r_sum  <= o_sum_next;
        end
    end

endmodule

[sim/tb_motor_feedback_tracker.sv]
// Self-checking testbench for the motor feedback tracker: directed cases, then randomized traffic.
`timescale 1ns / 1ps

// The testbench drives feedback frame and heartbeat tick transactions into the
// tracker and keeps its own model of the motor table: last angle, multi-turn
// sum, seeded flag, silence counter and offline flag per motor, plus the two
// configuration registers. Every accepted input transaction is run through
// that model right away and the predicted result is queued. A separate
// process compares each accepted result transaction field by field with the
// oldest queued prediction.
//
// Inputs change on the falling clock edge and outputs are sampled on the
// rising edge. Configuration writes happen only once the tracker has drained:
// the input side goes quiet, every predicted result has come back and the
// pipeline is then left to settle.
module tb_motor_feedback_tracker;
    import mft_pkg::*;

    localparam int N_MOTORS    = 16;
    localparam int PIPE_DEPTH  = 2;
    localparam int CYCLE_LIMIT = 400000;

    // Register indexes that the tracker must ignore.
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    // One input transaction: opcode, motor index and the seven raw bytes.
    // raw[0] is byte0 (angle high) through raw[6] (temperature).
    typedef struct packed {
        logic            op;
        logic [3:0]      motor;
        logic [6:0][7:0] raw;
    } t_fb_item;

    // One result transaction as the tracker reports it.
    typedef struct packed {
        logic [3:0]         motor;
        logic [15:0]        angle_raw;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temperature;
        logic signed [31:0] angle_total;
        logic [15:0]        flags;
        logic [4:0]         total;
    } t_fb_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_op;
    logic [3:0]         i_motor_index;
    logic [7:0]         i_byte0;
    logic [7:0]         i_byte1;
    logic [7:0]         i_byte2;
    logic [7:0]         i_byte3;
    logic [7:0]         i_byte4;
    logic [7:0]         i_byte5;
    logic [7:0]         i_byte6;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [3:0]         o_out_motor;
    logic [15:0]        o_angle_raw;
    logic signed [15:0] o_speed;
    logic signed [15:0] o_current;
    logic [7:0]         o_temperature;
    logic signed [31:0] o_angle_total;
    logic [15:0]        o_offline_flags;
    logic [4:0]         o_offline_total;

    motor_feedback_tracker #(
        .NUM_MOTORS(N_MOTORS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_motor_index  (i_motor_index),
        .i_byte0        (i_byte0),
        .i_byte1        (i_byte1),
        .i_byte2        (i_byte2),
        .i_byte3        (i_byte3),
        .i_byte4        (i_byte4),
        .i_byte5        (i_byte5),
        .i_byte6        (i_byte6),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_motor    (o_out_motor),
        .o_angle_raw    (o_angle_raw),
        .o_speed        (o_speed),
        .o_current      (o_current),
        .o_temperature  (o_temperature),
        .o_angle_total  (o_angle_total),
        .o_offline_flags(o_offline_flags),
        .o_offline_total(o_offline_total)
    );

    // Model copy of the configuration registers.
    logic [15:0] limit_reg;
    logic [15:0] mask_reg;

    // Model copy of the per-motor state.
    logic [15:0] last_angle [N_MOTORS];
    logic [31:0] turn_sum   [N_MOTORS];
    logic        seeded     [N_MOTORS];
    logic [15:0] silence    [N_MOTORS];
    logic        offline    [N_MOTORS];

    t_fb_result expected_results[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int fail_count         = 0;
    int cycle_count        = 0;
    int frames_sent        = 0;
    int ticks_sent         = 0;
    int cfg_writes         = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Runaway guard: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Apply one transaction to the model and return the result it predicts.
    // A frame unwraps the angle of its motor and clears its silence counter;
    // a tick advances every counter and re-evaluates every offline flag.
    function automatic t_fb_result track_feedback(input t_fb_item it);
        t_fb_result  r;
        logic [15:0] angle;
        logic [15:0] diff;
        logic [16:0] next_count;
        int          d;
        int          turn_step;
        r = '0;
        if (it.op == OP_FRAME) begin
            angle         = {it.raw[0], it.raw[1]};
            r.motor       = it.motor;
            r.angle_raw   = angle;
            r.speed       = {it.raw[2], it.raw[3]};
            r.current     = {it.raw[4], it.raw[5]};
            r.temperature = it.raw[6];
            // With a 4-bit index and sixteen motors every index is in the table.
            if (int'(it.motor) < N_MOTORS) begin
                // The first frame of a motor seeds its reference angle.
                if (!seeded[it.motor]) begin
                    seeded[it.motor]     = 1'b1;
                    last_angle[it.motor] = angle;
                    turn_sum[it.motor]   = '0;
                end
                diff = angle - last_angle[it.motor];
                d    = $signed(diff);
                // A jump of more than half a turn is taken as a wrap of the encoder.
                if (d > HALF_TURN) begin
                    turn_step = d - FULL_TURN;
                end else if (d < -HALF_TURN) begin
                    turn_step = d + FULL_TURN;
                end else begin
                    turn_step = d;
                end
                turn_sum[it.motor]   = turn_sum[it.motor] + turn_step;
                last_angle[it.motor] = angle;
                silence[it.motor]    = '0;
                r.angle_total        = turn_sum[it.motor];
            end
        end else begin
            for (int i = 0; i < N_MOTORS; i++) begin
                // The counter is widened so that a limit of 65535 saturates.
                next_count = {1'b0, silence[i]} + 17'd1;
                if (next_count > {1'b0, limit_reg}) begin
                    silence[i] = limit_reg;
                    offline[i] = 1'b1;
                end else begin
                    silence[i] = next_count[15:0];
                    offline[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < N_MOTORS && i < 16; i++) begin
            r.flags[i] = offline[i];
        end
        r.total = 5'($countones(r.flags & mask_reg));
        return r;
    endfunction

    function automatic t_fb_item frame_item(input logic [3:0] motor, input logic [15:0] angle,
                                            input logic [15:0] speed, input logic [15:0] current,
                                            input logic [7:0] temperature);
        t_fb_item it;
        it.op     = OP_FRAME;
        it.motor  = motor;
        it.raw[0] = angle[15:8];
        it.raw[1] = angle[7:0];
        it.raw[2] = speed[15:8];
        it.raw[3] = speed[7:0];
        it.raw[4] = current[15:8];
        it.raw[5] = current[7:0];
        it.raw[6] = temperature;
        return it;
    endfunction

    // A tick carries random payload bytes that the tracker must not use.
    function automatic t_fb_item tick_item();
        t_fb_item it;
        it.op    = OP_TICK;
        it.motor = 4'($urandom);
        it.raw   = 56'({$urandom, $urandom});
        return it;
    endfunction

    // Offer one transaction after a random idle gap and hold it until accepted.
    // Valid is left high afterwards; the next call or a drain decides its fate,
    // so it is never lowered and raised within one time step.
    task automatic send_item(input t_fb_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_motor_index <= it.motor;
        i_byte0       <= it.raw[0];
        i_byte1       <= it.raw[1];
        i_byte2       <= it.raw[2];
        i_byte3       <= it.raw[3];
        i_byte4       <= it.raw[4];
        i_byte5       <= it.raw[5];
        i_byte6       <= it.raw[6];
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(track_feedback(it));
        if (it.op == OP_FRAME) begin
            frames_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline settle.
    task automatic drain_tracker();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Single-cycle register write; the model follows the same decode.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_OFFLINE_LIMIT: limit_reg = data;
            REG_COUNT_MASK:    mask_reg  = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random stall, then compare each accepted result transaction.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_fb_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected (motor %0d)", o_out_motor);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_motor",     want.motor,       o_out_motor);
                check_field("angle_raw",     want.angle_raw,   o_angle_raw);
                check_field("speed",         want.speed,       o_speed);
                check_field("current",       want.current,     o_current);
                check_field("temperature",   want.temperature, o_temperature);
                check_field("angle_total",   want.angle_total, o_angle_total);
                check_field("offline_flags", want.flags,       o_offline_flags);
                check_field("offline_total", want.total,       o_offline_total);
            end
        end
    end

    // Right after reset every motor is offline, so a tick reports all sixteen.
    task automatic test_reset_tick();
        send_item(tick_item());
    endtask

    // Seeding, the unwrap thresholds on both sides, 16-bit difference wrap,
    // and the extremes of the speed, current and temperature fields.
    task automatic test_angle_unwrap();
        send_item(frame_item(4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00));
        send_item(frame_item(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_item(frame_item(4'd0,  16'h0FFF, 16'h7FFF, 16'h8000, 8'h01));
        send_item(frame_item(4'd0,  16'h1FFF, 16'h8000, 16'h7FFF, 8'h80));
        send_item(frame_item(4'd0,  16'h0000, 16'h0001, 16'hFFFE, 8'h7F));
        send_item(frame_item(4'd0,  16'h8000, 16'hAAAA, 16'h5555, 8'hAA));
        send_item(frame_item(4'd0,  16'h7FFF, 16'h5555, 16'hAAAA, 8'h55));
        send_item(frame_item(4'd15, 16'h7000, 16'h1234, 16'hEDCB, 8'h33));
        // Motors 0 and 15 were heard from and come back online.
        send_item(tick_item());
    endtask

    // Zero limit, saturation at a small limit, and a limit change that leaves
    // the counters alone until the next tick.
    task automatic test_offline_limit();
        drain_tracker();
        write_reg(REG_OFFLINE_LIMIT, 16'd0);
        send_item(tick_item());
        send_item(frame_item(4'd3, 16'h0100, 16'h0000, 16'h0000, 8'h20));
        send_item(tick_item());
        drain_tracker();
        write_reg(REG_OFFLINE_LIMIT, 16'd2);
        send_item(tick_item());
        send_item(tick_item());
        send_item(tick_item());
        drain_tracker();
        write_reg(REG_OFFLINE_LIMIT, 16'hFFFF);
        send_item(tick_item());
    endtask

    // Count mask extremes, a sparse mask, and writes to unused indexes.
    task automatic test_count_mask();
        drain_tracker();
        write_reg(REG_OFFLINE_LIMIT, 16'd0);
        write_reg(REG_COUNT_MASK, 16'h0000);
        send_item(tick_item());
        drain_tracker();
        write_reg(REG_COUNT_MASK, 16'hA5A5);
        send_item(tick_item());
        drain_tracker();
        write_reg(REG_SPARE_A, 16'h1234);
        write_reg(REG_SPARE_B, 16'hFFFF);
        send_item(tick_item());
        drain_tracker();
        write_reg(REG_COUNT_MASK, 16'hFFFF);
        write_reg(REG_OFFLINE_LIMIT, RESET_OFFLINE_LIMIT);
    endtask

    // Randomized traffic under one idling pattern, after a fresh random
    // configuration. Most frames move the angle a little from where the motor
    // last was, some jump across the half-turn threshold in either direction,
    // and a few carry a fully random angle.
    task automatic run_traffic(input int n_items, input int idle_pct, input int stall_pct,
                               input bit hold_midway);
        logic [3:0]  m;
        logic [15:0] angle;
        logic [15:0] limit_pick;
        int          a;
        drain_tracker();
        case ($urandom_range(5))
            0:       limit_pick = 16'd0;
            1:       limit_pick = 16'($urandom_range(3, 1));
            2:       limit_pick = 16'($urandom_range(12, 4));
            3:       limit_pick = RESET_OFFLINE_LIMIT;
            4:       limit_pick = 16'd65534;
            default: limit_pick = 16'($urandom);
        endcase
        write_reg(REG_OFFLINE_LIMIT, limit_pick);
        write_reg(REG_COUNT_MASK, ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            // Hold off the sender once until everything in flight has come back.
            if (hold_midway && k == n_items / 2) begin
                drain_tracker();
            end
            if ($urandom_range(99) < 15) begin
                send_item(tick_item());
            end else begin
                m = 4'($urandom);
                case ($urandom_range(9))
                    0:       a = int'($urandom_range(65535));
                    1:       a = int'(last_angle[m]) + int'($urandom_range(8191, 4096));
                    2:       a = int'(last_angle[m]) - int'($urandom_range(8191, 4096));
                    default: a = int'(last_angle[m]) + int'($urandom_range(600)) - 300;
                endcase
                angle = ($urandom_range(9) == 0) ? 16'(a) : (16'(a) & 16'h1FFF);
                send_item(frame_item(m, angle, 16'($urandom), 16'($urandom), 8'($urandom)));
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_OFFLINE_LIMIT;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_op          = OP_FRAME;
        i_motor_index = '0;
        i_byte0       = '0;
        i_byte1       = '0;
        i_byte2       = '0;
        i_byte3       = '0;
        i_byte4       = '0;
        i_byte5       = '0;
        i_byte6       = '0;
        limit_reg     = RESET_OFFLINE_LIMIT;
        mask_reg      = RESET_COUNT_MASK;
        for (int i = 0; i < N_MOTORS; i++) begin
            last_angle[i] = '0;
            turn_sum[i]   = '0;
            seeded[i]     = 1'b0;
            silence[i]    = RESET_SILENCE;
            offline[i]    = 1'b1;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_tick();
        test_angle_unwrap();
        test_offline_limit();
        test_count_mask();

        run_traffic(128, 0,  0,  1'b0);
        run_traffic(128, 49, 0,  1'b0);
        run_traffic(128, 0,  49, 1'b1);
        run_traffic(128, 19, 19, 1'b0);
        run_traffic(128, 0,  0,  1'b0);
        run_traffic(128, 49, 0,  1'b0);
        run_traffic(128, 0,  49, 1'b0);
        run_traffic(128, 19, 19, 1'b1);

        drain_tracker();
        $display("Sent %0d feedback frames and %0d heartbeat ticks with %0d register writes,",
                 frames_sent, ticks_sent, cfg_writes);
        $display("across unwrap edge cases, limit and mask extremes, and mixed idle/stall phases.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/mft_pkg.sv
sv/mft_lane.sv
sv/motor_feedback_tracker.sv
sim/tb_motor_feedback_tracker.sv
